// ----- hw/rtl/lps_pkg.sv -----
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types and constants for the lookahead point search block.
// ----------------------------------------------------------------------------
package lps_pkg;

  // Field widths
  localparam int DATA_W   = 24;          // Q12.12 coordinate
  localparam int IDX_W    = 10;          // waypoint index field
  localparam int LEN_W    = 11;          // path length register
  localparam int LD_W     = 23;          // lookahead_distance register
  localparam int LSQ_W    = 2 * LD_W;    // lookahead distance squared
  localparam int DIFF_W   = DATA_W + 1;  // exact coordinate difference
  localparam int SQ_W     = 2 * DIFF_W;  // one squared difference
  localparam int SUM_W    = SQ_W + 1;    // sum of both squares
  localparam int WP_W     = 2 * DATA_W;  // one stored waypoint {x, y}

  // Configuration port
  localparam int PDATA_W  = 32;
  localparam int PADDR_W  = 3;
  localparam logic [PADDR_W-1:0] ADDR_PATH_LEN  = 3'h0;
  localparam logic [PADDR_W-1:0] ADDR_LOOKAHEAD = 3'h4;

  localparam logic [LEN_W-1:0] PATH_LEN_RST  = 11'd0;
  localparam logic [LD_W-1:0]  LOOKAHEAD_RST = 23'd2048;

  // Default path memory depth
  localparam int PATH_DEPTH_DEF = 1024;

  // Input word operation codes
  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  // Configuration register values
  typedef struct packed {
    logic [LEN_W-1:0] path_len;
    logic [LD_W-1:0]  lookahead_distance;
  } lps_cfg_t;

  // Tag that travels with each waypoint read
  typedef struct packed {
    logic valid;
    logic last;
  } lps_tag_t;

  // Distance test result for one waypoint
  typedef struct packed {
    logic              valid;
    logic              last;
    logic              hit;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
  } lps_res_t;

endpackage

// ----- hw/rtl/lps_if.sv -----
// ----------------------------------------------------------------------------
// lps_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface lps_in_if import lps_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               mode;
  logic [IDX_W-1:0]         index;
  logic signed [DATA_W-1:0] pos_x;
  logic signed [DATA_W-1:0] pos_y;

  modport source (output valid, mode, index, pos_x, pos_y, input ready);
  modport sink   (input valid, mode, index, pos_x, pos_y, output ready);
endinterface

interface lps_out_if import lps_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     found;
  logic signed [DATA_W-1:0] target_x;
  logic signed [DATA_W-1:0] target_y;
  logic [IDX_W-1:0]         target_index;

  modport source (output valid, found, target_x, target_y, target_index, input ready);
  modport sink   (input valid, found, target_x, target_y, target_index, output ready);
endinterface

// ----- hw/rtl/lps_ram.sv -----
// ----------------------------------------------------------------------------
// lps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lps_ram #(
  parameter  int Width = 8,
  parameter  int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/lps_cfg.sv -----
// ----------------------------------------------------------------------------
// lps_cfg
// APB-style register file for path length and lookahead distance.
// ----------------------------------------------------------------------------
module lps_cfg import lps_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output lps_cfg_t           cfg_o
);

  logic [LEN_W-1:0] path_len_q;
  logic [LD_W-1:0]  lookahead_q;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Register writes in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      path_len_q  <= PATH_LEN_RST;
      lookahead_q <= LOOKAHEAD_RST;
    end else if (wr_en) begin
      unique case (paddr)
        ADDR_PATH_LEN:  path_len_q  <= pwdata[LEN_W-1:0];
        ADDR_LOOKAHEAD: lookahead_q <= pwdata[LD_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (paddr)
      ADDR_PATH_LEN:  prdata = PDATA_W'(path_len_q);
      ADDR_LOOKAHEAD: prdata = PDATA_W'(lookahead_q);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o.path_len           = path_len_q;
  assign cfg_o.lookahead_distance = lookahead_q;

endmodule

// ----- hw/rtl/lps_dist.sv -----
// ----------------------------------------------------------------------------
// lps_dist
// Distance pipeline: takes waypoints as they leave the path memory, forms the
// squared distance to the robot and compares it with the lookahead squared.
// ----------------------------------------------------------------------------
module lps_dist import lps_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     flush_i,
  input  lps_tag_t                 tag_i,     // issued with the memory read
  input  logic [WP_W-1:0]          rdata_i,   // memory data, in the cycle after the read
  input  logic signed [DATA_W-1:0] px_i,
  input  logic signed [DATA_W-1:0] py_i,
  input  logic [LSQ_W-1:0]         lsq_i,
  output lps_res_t                 res_o
);

  lps_tag_t              s1_q, s2_q, s3_q;
  logic [DATA_W-1:0]     x2_q, y2_q, x3_q, y3_q;
  logic signed [DIFF_W-1:0] dx_q, dy_q;
  logic [SQ_W-1:0]       sqx_q, sqy_q;
  logic [DATA_W-1:0]     wx, wy;
  logic [SUM_W-1:0]      sum;

  assign wx = rdata_i[WP_W-1:DATA_W];
  assign wy = rdata_i[DATA_W-1:0];

  // Advance stage tags; drop everything in flight on flush
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
    end else if (flush_i) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
    end else begin
      s1_q <= tag_i;
      s2_q <= s1_q;
      s3_q <= s2_q;
    end
  end

  // Differences, then squares
  always_ff @(posedge clk_i) begin
    dx_q  <= $signed({wx[DATA_W-1], wx}) - $signed({px_i[DATA_W-1], px_i});
    dy_q  <= $signed({wy[DATA_W-1], wy}) - $signed({py_i[DATA_W-1], py_i});
    x2_q  <= wx;
    y2_q  <= wy;
    sqx_q <= SQ_W'(dx_q * dx_q);
    sqy_q <= SQ_W'(dy_q * dy_q);
    x3_q  <= x2_q;
    y3_q  <= y2_q;
  end

  // Sum and compare
  assign sum = {1'b0, sqx_q} + {1'b0, sqy_q};

  assign res_o.valid = s3_q.valid;
  assign res_o.last  = s3_q.last;
  assign res_o.hit   = (sum >= SUM_W'(lsq_i));
  assign res_o.x     = x3_q;
  assign res_o.y     = y3_q;

endmodule

// ----- hw/rtl/lookahead_point_search_top.sv -----
// ----------------------------------------------------------------------------
// lookahead_point_search_top
// Path memory and search sequencer for the pure-pursuit lookahead point.
// ----------------------------------------------------------------------------
// A query walks the stored path from the remembered start index, reading one
// waypoint per cycle from the single read port of the path memory into a
// three-stage distance pipeline, and ends at the first waypoint at or beyond
// the lookahead radius or at the end of the path; that memory port sets the
// walk rate. The next input word is taken while a result word still waits at
// the output register. Stored waypoints are undefined until written.
module lookahead_point_search_top import lps_pkg::*; #(
  parameter int PATH_DEPTH = PATH_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  lps_in_if.sink             in_i,
  lps_out_if.source          out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int AW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
  localparam int CW = $clog2(PATH_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  lps_cfg_t cfg;
  lps_tag_t tag;
  lps_res_t res;

  logic signed [DATA_W-1:0] px_q, py_q;
  logic [LSQ_W-1:0]         lsq_q;
  logic [CW-1:0]            len_q, cnt_q, res_idx_q;
  logic                     issue_done_q;
  logic [IDX_W-1:0]         search_start_q;

  logic                     found_q;
  logic [DATA_W-1:0]        sel_x_q, sel_y_q;
  logic [IDX_W-1:0]         sel_idx_q;

  logic                     out_valid_q;
  logic                     out_found_q;
  logic [DATA_W-1:0]        out_x_q, out_y_q;
  logic [IDX_W-1:0]         out_idx_q;

  logic                     in_fire, wr_en, issue, finish, emit;
  logic [31:0]              len32, start32;
  logic [WP_W-1:0]          rdata;

  // Configuration registers
  lps_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .cfg_o (cfg)
  );

  // Input handshake
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid & in_i.ready;
  assign wr_en      = in_fire && (mode_e'(in_i.mode) == MODE_WRITE)
                      && (32'(in_i.index) < PATH_DEPTH);

  // Effective length and start index
  assign len32   = (32'(cfg.path_len) > PATH_DEPTH) ? 32'(PATH_DEPTH)
                                                    : 32'(cfg.path_len);
  assign start32 = (32'(search_start_q) >= len32) ? 32'd0 : 32'(search_start_q);

  // Walk issue and completion
  assign issue  = (state_q == ST_WALK) && !issue_done_q;
  assign tag.valid = issue;
  assign tag.last  = (cnt_q == len_q - CW'(1));
  assign finish = (state_q == ST_WALK) && res.valid && (res.hit || res.last);
  assign emit   = (state_q == ST_EMIT) && (!out_valid_q || out_o.ready);

  // Path memory, {x, y} per slot
  lps_ram #(
    .Width (WP_W),
    .Depth (PATH_DEPTH)
  ) u_path_ram (
    .clk_i,
    .we_i    (wr_en),
    .waddr_i (AW'(in_i.index)),
    .wdata_i ({in_i.pos_x, in_i.pos_y}),
    .re_i    (issue),
    .raddr_i (cnt_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // Distance pipeline
  lps_dist u_dist (
    .clk_i,
    .rst_ni,
    .flush_i (finish),
    .tag_i   (tag),
    .rdata_i (rdata),
    .px_i    (px_q),
    .py_i    (py_q),
    .lsq_i   (lsq_q),
    .res_o   (res)
  );

  // Lookahead squared, refreshed every cycle
  always_ff @(posedge clk_i) begin
    lsq_q <= LSQ_W'(cfg.lookahead_distance * cfg.lookahead_distance);
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (mode_e'(in_i.mode) == MODE_QUERY)) state_d = ST_START;
      end
      ST_START: begin
        state_d = (len32 == 32'd0) ? ST_EMIT : ST_WALK;
      end
      ST_WALK: begin
        if (finish) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Search start index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_start_q <= '0;
    end else if (in_fire && (mode_e'(in_i.mode) == MODE_CLEAR)) begin
      search_start_q <= '0;
    end else if ((state_q == ST_START) && (len32 != 32'd0)) begin
      search_start_q <= IDX_W'(start32);
    end else if (finish && res.hit) begin
      search_start_q <= IDX_W'(res_idx_q);
    end
  end

  // Walk counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_done_q <= 1'b1;
    end else if (state_q == ST_START) begin
      issue_done_q <= 1'b0;
    end else if (issue && tag.last) begin
      issue_done_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      px_q <= in_i.pos_x;
      py_q <= in_i.pos_y;
    end
    if (state_q == ST_START) begin
      len_q     <= CW'(len32);
      cnt_q     <= CW'(start32);
      res_idx_q <= CW'(start32);
    end else begin
      if (issue) cnt_q <= cnt_q + CW'(1);
      if (res.valid && !finish) res_idx_q <= res_idx_q + CW'(1);
    end
  end

  // Selected waypoint
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_START) && (len32 == 32'd0)) begin
      found_q   <= 1'b0;
      sel_x_q   <= '0;
      sel_y_q   <= '0;
      sel_idx_q <= '0;
    end else if (finish) begin
      found_q   <= 1'b1;
      sel_x_q   <= res.x;
      sel_y_q   <= res.y;
      sel_idx_q <= IDX_W'(res_idx_q);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_found_q <= found_q;
      out_x_q     <= sel_x_q;
      out_y_q     <= sel_y_q;
      out_idx_q   <= sel_idx_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.found        = out_found_q;
  assign out_o.target_x     = out_x_q;
  assign out_o.target_y     = out_y_q;
  assign out_o.target_index = out_idx_q;

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the lookahead point search block. The block stores waypoints
// and answers position queries. This bench drives waypoint, query and clear
// words through the input channel. It sets the path length and the lookahead
// radius over the APB port while the block is idle. Each accepted word goes
// through a local model of the path search. Every result word is checked
// against the oldest pending target. A directed section covers the edge cases.
// A random section then runs paths of varying length, each followed along by
// a moving robot position, with idle bursts on both channels in most of them.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import lps_pkg::*;

  localparam int PATH_DEPTH   = PATH_DEPTH_DEF;
  localparam int MAX_GAP      = 9;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 32;
  localparam int ITEM_BOUND   = 2200;
  localparam int unsigned CYCLE_LIMIT =
    ITEM_BOUND * (PATH_DEPTH + 16 + 2 * MAX_GAP) * 3 + LONG_HOLD;
  localparam int METRE        = 4096;  // 1.0 in Q12.12

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic signed [DATA_W-1:0] COORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] COORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam int unsigned RADIUS_TOP = (1 << LD_W) - 1;

  typedef struct packed {
    logic                     found;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic [IDX_W-1:0]         index;
  } target_t;

  typedef enum int {
    RADIUS_ALONG,
    RADIUS_ZERO,
    RADIUS_MAX
  } radius_kind_e;

  // Track the stored path and search index, and queue the targets to come
  class target_predictor;
    logic signed [DATA_W-1:0] wp_x [PATH_DEPTH];
    logic signed [DATA_W-1:0] wp_y [PATH_DEPTH];
    logic [IDX_W-1:0]         start_idx;
    logic [LEN_W-1:0]         path_len;
    logic [LD_W-1:0]          radius;
    target_t                  pending_targets [$];
    int unsigned              errors;

    function new();
      start_idx = '0;
      path_len  = PATH_LEN_RST;
      radius    = LOOKAHEAD_RST;
      errors    = 0;
    endfunction

    function void set_register(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
      if (addr == ADDR_PATH_LEN) begin
        path_len = data[LEN_W-1:0];
      end else if (addr == ADDR_LOOKAHEAD) begin
        radius = data[LD_W-1:0];
      end
    endfunction

    function void note_word(logic [1:0] mode, logic [IDX_W-1:0] idx,
                            logic signed [DATA_W-1:0] px, logic signed [DATA_W-1:0] py);
      int unsigned len;
      int unsigned i;
      int unsigned sel;
      longint      radius_sq;
      longint      dx;
      longint      dy;
      bit          hit;
      target_t     t;
      case (mode)
        MODE_WRITE: begin
          if (idx < PATH_DEPTH) begin
            wp_x[idx] = px;
            wp_y[idx] = py;
          end
        end
        MODE_CLEAR: begin
          start_idx = '0;
        end
        MODE_QUERY: begin
          t   = '0;
          len = (path_len > PATH_DEPTH) ? PATH_DEPTH : path_len;
          if (len != 0) begin
            // Restart a stale index before the walk
            if (start_idx >= len) start_idx = '0;
            radius_sq = longint'(radius) * longint'(radius);
            sel = len - 1;
            hit = 1'b0;
            for (i = start_idx; i < len && !hit; i++) begin
              dx = longint'(wp_x[i]) - longint'(px);
              dy = longint'(wp_y[i]) - longint'(py);
              if (dx * dx + dy * dy >= radius_sq) begin
                sel = i;
                hit = 1'b1;
              end
            end
            // Keep the index when no waypoint lies at or beyond the radius
            if (hit) start_idx = IDX_W'(sel);
            t.found = 1'b1;
            t.x     = wp_x[sel];
            t.y     = wp_y[sel];
            t.index = IDX_W'(sel);
          end
          pending_targets.push_back(t);
        end
        default: begin
        end
      endcase
    endfunction

    function void compare(string field, logic signed [DATA_W:0] want,
                          logic signed [DATA_W:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_target(target_t got);
      target_t want;
      if (pending_targets.size() == 0) begin
        $error("result word with no query pending: index %0d", got.index);
        errors++;
        return;
      end
      want = pending_targets.pop_front();
      compare("found", want.found, got.found);
      compare("target_x", want.x, got.x);
      compare("target_y", want.y, got.y);
      compare("target_index", want.index, got.index);
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  lps_in_if  in_if ();
  lps_out_if out_if ();

  target_predictor predictor = new();
  int unsigned     cycle_count = 0;
  int unsigned     idle_pct = 0;
  bit              long_hold_req;
  int              route_x [PATH_DEPTH];
  int              route_y [PATH_DEPTH];

  lookahead_point_search_top #(
    .PATH_DEPTH(PATH_DEPTH)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Stop a hung run
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_top failed");
    $finish;
  end

  // Uniform integer in [-half, half]
  function automatic int spread(int unsigned half);
    return int'($urandom_range(0, 2 * half)) - int'(half);
  endfunction

  // Offer one word, with an optional idle burst first, and hold it until taken
  task automatic send_word(logic [1:0] mode, logic [IDX_W-1:0] idx,
                           logic signed [DATA_W-1:0] px, logic signed [DATA_W-1:0] py);
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, MAX_GAP)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.mode  <= mode;
    in_if.index <= idx;
    in_if.pos_x <= px;
    in_if.pos_y <= py;
    do @(posedge clk_i); while (!in_if.ready);
    predictor.note_word(mode, idx, px, py);
  endtask

  // Drop valid, wait for every pending target, then let the block go quiet
  task automatic settle();
    in_if.valid <= 1'b0;
    while (predictor.pending_targets.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    predictor.set_register(addr, data);
  endtask

  task automatic configure(int unsigned len_reg, int unsigned radius);
    settle();
    apb_write(ADDR_PATH_LEN, PDATA_W'(len_reg));
    apb_write(ADDR_LOOKAHEAD, PDATA_W'(radius));
  endtask

  // Lay out a path, then follow it with queries mixed with edits and clears
  task automatic run_phase(int unsigned len_reg, radius_kind_e kind, int unsigned n_items,
                           int unsigned step_max, bit refill, bit hold_out);
    int unsigned len;
    int unsigned j;
    int unsigned r;
    int unsigned slot;
    int unsigned radius;
    int          x0;
    int          y0;
    int          sx;
    int          sy;
    logic signed [DATA_W-1:0] wx;
    logic signed [DATA_W-1:0] wy;
    len = (len_reg > PATH_DEPTH) ? PATH_DEPTH : len_reg;
    x0  = spread(1 << 21);
    y0  = spread(1 << 21);
    sx  = spread(step_max);
    sy  = spread(step_max);
    case (kind)
      RADIUS_ZERO: radius = 0;
      RADIUS_MAX:  radius = RADIUS_TOP;
      default:     radius = (((sx < 0) ? -sx : sx) + ((sy < 0) ? -sy : sy)) / 2 + 1;
    endcase
    if (kind == RADIUS_ALONG) radius = radius * $urandom_range(1, 8);
    configure(len_reg, radius);

    if (refill) begin
      for (int k = 0; k < len; k++) begin
        route_x[k] = x0 + k * sx + spread(step_max / 4);
        route_y[k] = y0 + k * sy + spread(step_max / 4);
        send_word(MODE_WRITE, IDX_W'(k), DATA_W'(route_x[k]), DATA_W'(route_y[k]));
      end
    end

    if (hold_out) long_hold_req <= 1'b1;
    j = 0;
    for (int n = 0; n < n_items; n++) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        // Robot near the path, moving forward with the odd jump
        send_word(MODE_QUERY, IDX_W'($urandom),
                  DATA_W'(route_x[j] + spread(step_max / 2)),
                  DATA_W'(route_y[j] + spread(step_max / 2)));
        if (len != 0 && $urandom_range(0, 15) == 0) begin
          j = $urandom_range(0, len - 1);
        end else begin
          j = j + $urandom_range(0, 2);
        end
        if (j >= len) j = (len == 0) ? 0 : len - 1;
      end else if (r < 78) begin
        send_word(MODE_QUERY, IDX_W'($urandom), DATA_W'($urandom), DATA_W'($urandom));
      end else if (r < 82) begin
        // Nudge one waypoint of the live path
        slot = (len != 0) ? $urandom_range(0, len - 1) : $urandom_range(0, PATH_DEPTH - 1);
        route_x[slot] = route_x[slot] + spread(step_max / 4);
        route_y[slot] = route_y[slot] + spread(step_max / 4);
        send_word(MODE_WRITE, IDX_W'(slot), DATA_W'(route_x[slot]), DATA_W'(route_y[slot]));
      end else if (r < 86) begin
        slot = $urandom_range(0, PATH_DEPTH - 1);
        wx   = DATA_W'($urandom);
        wy   = DATA_W'($urandom);
        if (slot < len) begin
          route_x[slot] = int'(wx);
          route_y[slot] = int'(wy);
        end
        send_word(MODE_WRITE, IDX_W'(slot), wx, wy);
      end else if (r < 93) begin
        send_word(MODE_CLEAR, IDX_W'($urandom), DATA_W'($urandom), DATA_W'($urandom));
        j = 0;
      end else begin
        send_word(MODE_UNUSED, IDX_W'($urandom), DATA_W'($urandom), DATA_W'($urandom));
        n--;
      end
    end
  endtask

  // Take result words with random stall bursts and one long hold-off
  initial begin : result_sink
    int unsigned stall_left;
    bit          hold_taken;
    target_t     got;
    stall_left = 0;
    hold_taken = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        got.found = out_if.found;
        got.x     = out_if.target_x;
        got.y     = out_if.target_y;
        got.index = out_if.target_index;
        predictor.check_target(got);
      end
      if (long_hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
        stall_left = $urandom_range(1, MAX_GAP);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_if.valid   <= 1'b0;
    in_if.mode    <= MODE_WRITE;
    in_if.index   <= '0;
    in_if.pos_x   <= '0;
    in_if.pos_y   <= '0;
    long_hold_req <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty path after reset, an unused mode and a clear
    send_word(MODE_QUERY, '0, '0, '0);
    send_word(MODE_UNUSED, '1, COORD_MAX, COORD_MIN);
    send_word(MODE_CLEAR, '0, '0, '0);

    // Straight path along x, one metre apart, plus the index extremes
    for (int k = 0; k < 8; k++) begin
      send_word(MODE_WRITE, IDX_W'(k), DATA_W'(k * METRE), '1);
    end
    send_word(MODE_WRITE, '1, COORD_MAX, COORD_MIN);
    send_word(MODE_WRITE, IDX_W'(PATH_DEPTH - 2), COORD_MIN, COORD_MAX);

    // Walk forward, then run off the end of the path
    configure(8, 10 * METRE / 4);
    send_word(MODE_QUERY, '0, '0, '1);
    send_word(MODE_QUERY, '0, DATA_W'(3 * METRE), '1);
    send_word(MODE_QUERY, '0, DATA_W'(6 * METRE), '1);

    // Shorten the path under the remembered index
    configure(4, 10 * METRE / 4);
    send_word(MODE_QUERY, '0, DATA_W'(6 * METRE), '1);

    // Radius exactly on a waypoint
    configure(8, 3 * METRE);
    send_word(MODE_CLEAR, '1, '1, '1);
    send_word(MODE_QUERY, '0, '0, '1);

    // Widest radius against the corner positions, then a zero radius
    configure(8, RADIUS_TOP);
    send_word(MODE_QUERY, '1, COORD_MIN, COORD_MAX);
    send_word(MODE_QUERY, '0, COORD_MAX, COORD_MIN);
    configure(8, 0);
    send_word(MODE_QUERY, '0, '0, '0);

    // Random paths, mostly short
    idle_pct = 20;
    run_phase(1, RADIUS_ALONG, 40, 1 << 14, 1'b1, 1'b0);
    run_phase(2, RADIUS_ALONG, 40, 1 << 14, 1'b1, 1'b0);
    run_phase(0, RADIUS_ALONG, 40, 1 << 14, 1'b1, 1'b0);
    idle_pct = 35;
    run_phase($urandom_range(3, 64), RADIUS_ALONG, 90, 1 << 14, 1'b1, 1'b1);
    idle_pct = 10;
    run_phase($urandom_range(3, 64), RADIUS_ZERO, 80, 1 << 14, 1'b1, 1'b0);
    run_phase($urandom_range(3, 64), RADIUS_MAX, 80, 1 << 14, 1'b1, 1'b0);
    idle_pct = 0;
    run_phase($urandom_range(3, 64), RADIUS_ALONG, 100, 1 << 14, 1'b1, 1'b0);
    idle_pct = 25;
    run_phase($urandom_range(3, 64), RADIUS_ALONG, 100, 1 << 14, 1'b1, 1'b0);
    run_phase($urandom_range(3, 64), RADIUS_ALONG, 100, 1 << 14, 1'b1, 1'b0);

    // Full memory, then a length register past the depth
    run_phase(PATH_DEPTH, RADIUS_ALONG, 40, 1 << 11, 1'b1, 1'b0);
    idle_pct = 0;
    run_phase((1 << LEN_W) - 1, RADIUS_ALONG, 40, 1 << 11, 1'b0, 1'b0);

    settle();
    if (predictor.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
